// ----- rtl/sdcm_pkg.sv -----
package sdcm_pkg;

    localparam int ADDR_W   = 5;
    localparam int DATA_W   = 32;
    localparam int THR_W    = 12;
    localparam int SPEED_W  = 13;
    localparam int BRAKE_W  = 14;
    localparam int STEER_W  = 17;
    localparam int SGAIN_W  = 13;
    localparam int TGAIN_W  = 8;

    localparam logic [THR_W-1:0]   RST_DB_LOW    = 12'd1900;
    localparam logic [THR_W-1:0]   RST_DB_HIGH   = 12'd2200;
    localparam logic [THR_W-1:0]   RST_UP_ARM    = 12'd3500;
    localparam logic [THR_W-1:0]   RST_UP_REL    = 12'd2500;
    localparam logic [THR_W-1:0]   RST_DN_ARM    = 12'd500;
    localparam logic [THR_W-1:0]   RST_DN_REL    = 12'd1500;
    localparam logic [SGAIN_W-1:0] RST_SPEED_GAIN = 13'd3814;
    localparam logic [TGAIN_W-1:0] RST_STEER_GAIN = 8'd200;

    localparam logic [SPEED_W-1:0] SPEED_MAX     = 13'd8191;
    localparam logic [BRAKE_W-1:0] BRAKE_FULL_Q8 = 14'd10240;
    localparam logic [STEER_W-1:0] STEER_LIMIT   = 17'd65280;

    typedef enum logic [1:0] {
        PH_IDLE      = 2'd0,
        PH_WAIT_UP   = 2'd1,
        PH_WAIT_DOWN = 2'd2
    } t_phase;

    typedef enum logic [2:0] {
        REG_DB_LOW     = 3'd0,
        REG_DB_HIGH    = 3'd1,
        REG_UP_ARM     = 3'd2,
        REG_UP_REL     = 3'd3,
        REG_DN_ARM     = 3'd4,
        REG_DN_REL     = 3'd5,
        REG_SPEED_GAIN = 3'd6,
        REG_STEER_GAIN = 3'd7
    } t_reg_idx;

endpackage

// ----- rtl/stick_to_drive_command_mapper.sv -----
// Stick to drive command mapper.
// Input channel (i_in_valid / o_in_ready): one remote frame per transaction,
// a link valid bit and three stick positions centred at 2^(STICK_BITS-1).
// Output channel (o_out_valid / i_out_ready): one drive command per frame,
// except for frames that arm a right stick toggle or are taken while it
// waits for release, which give none.
// A frame is captured in the input register at the accepting edge, mapped
// from there and loaded into the output register when the output register
// is free or its command is taken, so the command is registered.
// Throughput is one frame per cycle while the receiver does not stall, set by
// the single mapping stage between the two registers.
// A stalled receiver holds the command in the output register; the input
// register still takes one frame, and further frames wait until the
// command is taken (ready then follows i_out_ready in the same cycle).
// Reset clears the valid bits of both registers, the toggle phase, both latches
// and the held speed, brake and steer, and loads the default thresholds and gains.
// The user writes registers through the APB port only while no frame is in flight; the block does not enforce it.
module stick_to_drive_command_mapper #(
    parameter int STICK_BITS = 12
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sdcm_pkg::ADDR_W-1:0]     paddr,
    input  logic [sdcm_pkg::DATA_W-1:0]     pwdata,
    output logic [sdcm_pkg::DATA_W-1:0]     prdata,
    output logic                            pready,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_frame_valid,
    input  logic [STICK_BITS-1:0]           i_left_vertical,
    input  logic [STICK_BITS-1:0]           i_right_vertical,
    input  logic [STICK_BITS-1:0]           i_right_horizontal,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output logic                            o_command_valid,
    output logic                            o_hand_brake_on,
    output logic                            o_gear_drive,
    output logic [sdcm_pkg::BRAKE_W-1:0]    o_brake_q8,
    output logic [sdcm_pkg::SPEED_W-1:0]    o_speed_q8,
    output logic signed [sdcm_pkg::STEER_W-1:0] o_steer_q8
);
    import sdcm_pkg::*;

    localparam int CMP_W   = (STICK_BITS > THR_W) ? STICK_BITS : THR_W;
    localparam int SPROD_W = STICK_BITS + SGAIN_W;
    localparam int BPROD_W = STICK_BITS + BRAKE_W;
    localparam int TPROD_W = STICK_BITS + TGAIN_W;
    localparam int TEXT_W  = TPROD_W + 8;
    localparam logic [STICK_BITS-1:0] CENTRE = {1'b1, {(STICK_BITS-1){1'b0}}};

    // configuration
    logic [THR_W-1:0]   r_db_low, r_db_high, r_up_arm, r_up_rel, r_dn_arm, r_dn_rel;
    logic [SGAIN_W-1:0] r_speed_gain;
    logic [TGAIN_W-1:0] r_steer_gain;
    logic               w_cfg_wr;
    t_reg_idx           w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite;
    assign w_cfg_idx = t_reg_idx'(paddr[ADDR_W-1:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_db_low     <= RST_DB_LOW;
            r_db_high    <= RST_DB_HIGH;
            r_up_arm     <= RST_UP_ARM;
            r_up_rel     <= RST_UP_REL;
            r_dn_arm     <= RST_DN_ARM;
            r_dn_rel     <= RST_DN_REL;
            r_speed_gain <= RST_SPEED_GAIN;
            r_steer_gain <= RST_STEER_GAIN;
        end else if (w_cfg_wr) begin
            case (w_cfg_idx)
                REG_DB_LOW:     r_db_low     <= pwdata[THR_W-1:0];
                REG_DB_HIGH:    r_db_high    <= pwdata[THR_W-1:0];
                REG_UP_ARM:     r_up_arm     <= pwdata[THR_W-1:0];
                REG_UP_REL:     r_up_rel     <= pwdata[THR_W-1:0];
                REG_DN_ARM:     r_dn_arm     <= pwdata[THR_W-1:0];
                REG_DN_REL:     r_dn_rel     <= pwdata[THR_W-1:0];
                REG_SPEED_GAIN: r_speed_gain <= pwdata[SGAIN_W-1:0];
                REG_STEER_GAIN: r_steer_gain <= pwdata[TGAIN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_cfg_idx)
            REG_DB_LOW:     prdata = DATA_W'(r_db_low);
            REG_DB_HIGH:    prdata = DATA_W'(r_db_high);
            REG_UP_ARM:     prdata = DATA_W'(r_up_arm);
            REG_UP_REL:     prdata = DATA_W'(r_up_rel);
            REG_DN_ARM:     prdata = DATA_W'(r_dn_arm);
            REG_DN_REL:     prdata = DATA_W'(r_dn_rel);
            REG_SPEED_GAIN: prdata = DATA_W'(r_speed_gain);
            REG_STEER_GAIN: prdata = DATA_W'(r_steer_gain);
            default:        prdata = '0;
        endcase
    end

    // input register
    logic                  r_in_vld;
    logic                  r_fv;
    logic [STICK_BITS-1:0] r_lv, r_rv, r_rh;
    logic                  w_adv;

    assign o_in_ready = !r_in_vld || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (o_in_ready) begin
            r_in_vld <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_fv <= i_frame_valid;
            r_lv <= i_left_vertical;
            r_rv <= i_right_vertical;
            r_rh <= i_right_horizontal;
        end
    end

    // state
    t_phase               r_phase, n_phase;
    logic                 r_brake, n_brake;
    logic                 r_gear, n_gear;
    logic [SPEED_W-1:0]   r_held_speed, n_held_speed;
    logic [BRAKE_W-1:0]   r_held_brake, n_held_brake;
    logic [STEER_W-1:0]   r_held_steer, n_held_steer;
    logic                 w_emit;
    logic                 w_down_chk;

    // comparisons in a common width
    logic [CMP_W-1:0] w_lv, w_rv, w_rh;
    logic [CMP_W-1:0] w_db_low, w_db_high, w_up_arm, w_up_rel, w_dn_arm, w_dn_rel;

    assign w_lv      = CMP_W'(r_lv);
    assign w_rv      = CMP_W'(r_rv);
    assign w_rh      = CMP_W'(r_rh);
    assign w_db_low  = CMP_W'(r_db_low);
    assign w_db_high = CMP_W'(r_db_high);
    assign w_up_arm  = CMP_W'(r_up_arm);
    assign w_up_rel  = CMP_W'(r_up_rel);
    assign w_dn_arm  = CMP_W'(r_dn_arm);
    assign w_dn_rel  = CMP_W'(r_dn_rel);

    // speed from left stick above centre
    logic [STICK_BITS-1:0] w_spd_mag;
    logic [SPROD_W-1:0]    w_spd_prod, w_spd_shr;
    logic [SPEED_W-1:0]    w_spd_q8;

    assign w_spd_mag  = r_lv - CENTRE;
    assign w_spd_prod = SPROD_W'(w_spd_mag) * SPROD_W'(r_speed_gain);
    assign w_spd_shr  = w_spd_prod >> (STICK_BITS - 1);
    always_comb begin
        if (r_lv <= CENTRE) begin
            w_spd_q8 = '0;
        end else if (w_spd_shr > SPROD_W'(SPEED_MAX)) begin
            w_spd_q8 = SPEED_MAX;
        end else begin
            w_spd_q8 = w_spd_shr[SPEED_W-1:0];
        end
    end

    // brake from left stick below centre
    logic [STICK_BITS-1:0] w_brk_mag;
    logic [BPROD_W-1:0]    w_brk_prod, w_brk_shr;
    logic [BRAKE_W-1:0]    w_brk_q8;

    assign w_brk_mag  = CENTRE - r_lv;
    assign w_brk_prod = BPROD_W'(w_brk_mag) * BPROD_W'(BRAKE_FULL_Q8);
    assign w_brk_shr  = w_brk_prod >> (STICK_BITS - 1);
    always_comb begin
        if (r_lv >= CENTRE) begin
            w_brk_q8 = '0;
        end else if (w_brk_shr > BPROD_W'(BRAKE_FULL_Q8)) begin
            w_brk_q8 = BRAKE_FULL_Q8;
        end else begin
            w_brk_q8 = w_brk_shr[BRAKE_W-1:0];
        end
    end

    // steering, left positive, truncated toward zero
    logic                  w_str_neg;
    logic [STICK_BITS-1:0] w_str_mag;
    logic [TPROD_W-1:0]    w_str_prod;
    logic [TEXT_W-1:0]     w_str_shr;
    logic [STEER_W-1:0]    w_str_abs, w_str_q8;

    assign w_str_neg  = r_rh > CENTRE;
    assign w_str_mag  = w_str_neg ? (r_rh - CENTRE) : (CENTRE - r_rh);
    assign w_str_prod = TPROD_W'(w_str_mag) * TPROD_W'(r_steer_gain);
    assign w_str_shr  = {w_str_prod, 8'h00} >> (STICK_BITS - 1);
    assign w_str_abs  = (w_str_shr > TEXT_W'(STEER_LIMIT)) ? STEER_LIMIT
                                                            : w_str_shr[STEER_W-1:0];
    assign w_str_q8   = w_str_neg ? (STEER_W'(0) - w_str_abs) : w_str_abs;

    // toggle sequencing and command update
    always_comb begin
        n_phase      = r_phase;
        n_brake      = r_brake;
        n_gear       = r_gear;
        n_held_speed = r_held_speed;
        n_held_brake = r_held_brake;
        n_held_steer = r_held_steer;
        w_emit       = 1'b1;
        w_down_chk   = 1'b0;

        if (!r_fv) begin
            w_emit = !(r_phase == PH_WAIT_UP || r_phase == PH_WAIT_DOWN);
        end else begin
            case (r_phase)
                PH_WAIT_UP: begin
                    if (w_rv > w_up_rel) begin
                        w_emit = 1'b0;
                    end else begin
                        n_brake    = !r_brake;
                        n_phase    = PH_IDLE;
                        w_down_chk = 1'b1;
                    end
                end
                PH_WAIT_DOWN: begin
                    if (w_rv < w_dn_rel) begin
                        w_emit = 1'b0;
                    end else begin
                        n_gear  = !r_gear;
                        n_phase = PH_IDLE;
                    end
                end
                default: begin
                    n_phase    = PH_IDLE;
                    w_down_chk = 1'b1;
                    if (w_rv > w_up_arm) begin
                        if (w_rv <= w_up_rel) begin
                            n_brake = !r_brake;
                        end else begin
                            n_phase    = PH_WAIT_UP;
                            w_emit     = 1'b0;
                            w_down_chk = 1'b0;
                        end
                    end
                end
            endcase

            if (w_down_chk && (w_rv < w_dn_arm)) begin
                if (w_rv >= w_dn_rel) begin
                    n_gear = !r_gear;
                end else begin
                    n_phase = PH_WAIT_DOWN;
                    w_emit  = 1'b0;
                end
            end

            if (w_emit) begin
                if (!n_brake && n_gear) begin
                    if ((w_lv < w_db_high) && (w_lv > w_db_low)) begin
                        n_held_speed = '0;
                        n_held_brake = '0;
                    end else if (w_lv >= w_db_high) begin
                        n_held_speed = w_spd_q8;
                        n_held_brake = '0;
                    end else begin
                        n_held_speed = '0;
                        n_held_brake = w_brk_q8;
                    end
                end
                if (!n_gear || ((w_rh < w_db_high) && (w_rh > w_db_low))) begin
                    n_held_steer = '0;
                end else begin
                    n_held_steer = w_str_q8;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_brake      <= 1'b0;
            r_gear       <= 1'b0;
            r_held_speed <= '0;
            r_held_brake <= '0;
            r_held_steer <= '0;
        end else if (w_adv) begin
            r_phase      <= n_phase;
            r_brake      <= n_brake;
            r_gear       <= n_gear;
            r_held_speed <= n_held_speed;
            r_held_brake <= n_held_brake;
            r_held_steer <= n_held_steer;
        end
    end

    // output register
    logic r_out_vld;

    assign w_adv = r_in_vld && (!r_out_vld || i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_adv && w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_emit) begin
            o_command_valid <= r_fv;
            o_hand_brake_on <= n_brake;
            o_gear_drive    <= n_gear;
            o_brake_q8      <= n_held_brake;
            o_speed_q8      <= n_held_speed;
            o_steer_q8      <= signed'(n_held_steer);
        end
    end

    assign o_out_valid = r_out_vld;

endmodule

// ----- rtl/sdcm_checker.sv -----
module sdcm_checker (
    input logic                                 i_clk,
    input logic                                 i_rst_n,
    input logic                                 o_out_valid,
    input logic                                 i_out_ready,
    input logic                                 o_command_valid,
    input logic                                 o_hand_brake_on,
    input logic                                 o_gear_drive,
    input logic [sdcm_pkg::BRAKE_W-1:0]         o_brake_q8,
    input logic [sdcm_pkg::SPEED_W-1:0]         o_speed_q8,
    input logic signed [sdcm_pkg::STEER_W-1:0]  o_steer_q8
);
    import sdcm_pkg::*;

    a_reset_clears_output: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid after reset");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_command_valid)
            && $stable(o_hand_brake_on) && $stable(o_gear_drive)
            && $stable(o_brake_q8) && $stable(o_speed_q8) && $stable(o_steer_q8))
        else $error("stalled transaction changed");

    a_speed_brake_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_speed_q8 == '0) || (o_brake_q8 == '0))
        else $error("speed and brake both demanded");

    a_neutral_no_steer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_command_valid && !o_gear_drive |-> o_steer_q8 == '0)
        else $error("steering in neutral");

    a_brake_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_brake_q8 <= BRAKE_FULL_Q8)
        else $error("brake demand above full scale");

endmodule

bind stick_to_drive_command_mapper sdcm_checker u_sdcm_checker (.*);
